// ===== hw/rtl/csl_pkg.sv =====
// Shared types, codes and character constants of the character stream lexer.
`timescale 1ns / 1ps

package csl_pkg;

    // Token type codes carried on the result channel
    typedef enum logic [3:0] {
        KIND_ERROR  = 4'd0,
        KIND_EOF    = 4'd1,
        KIND_SYMBOL = 4'd2,
        KIND_ARROW  = 4'd3,
        KIND_EQUAL  = 4'd4,
        KIND_COLON  = 4'd5,
        KIND_SEMI   = 4'd6,
        KIND_LPAR   = 4'd7,
        KIND_RPAR   = 4'd8,
        KIND_NUMBER = 4'd9
    } t_kind;

    // Lexer mode: what kind of token is open
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_INT  = 3'd1,
        MODE_FRAC = 3'd2,
        MODE_SYM  = 3'd3,
        MODE_EQ   = 3'd4
    } t_mode;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_LPAR  = 8'h28;
    localparam logic [7:0] CHAR_RPAR  = 8'h29;

    localparam int QUEUE_DEPTH_DEF = 4;

    // One result item
    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic       present;
        logic       last;
    } t_result;

    // All results caused by one input item (one or two)
    typedef struct packed {
        t_result res0;
        t_result res1;
        logic    two;
    } t_entry;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== hw/rtl/csl_in_if.sv =====
// Input channel of the lexer: one character or end-of-stream mark per transfer.
`timescale 1ns / 1ps

interface csl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_stream;

    modport source (output valid, output char_code, output end_of_stream, input ready);
    modport sink   (input valid, input char_code, input end_of_stream, output ready);
endinterface

// ===== hw/rtl/csl_out_if.sv =====
// Result channel of the lexer: one tagged token character per transfer.
`timescale 1ns / 1ps

interface csl_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_kind;
    logic [7:0] token_char;
    logic       char_present;
    logic       token_last;

    modport source (output valid, output token_kind, output token_char,
                    output char_present, output token_last, input ready);
    modport sink   (input valid, input token_kind, input token_char,
                    input char_present, input token_last, output ready);
endinterface

// ===== hw/rtl/csl_front.sv =====
// Lexer front end: classifies each accepted character and builds its result entry.
`timescale 1ns / 1ps

module csl_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    csl_in_if.sink             i_in,
    input  csl_pkg::t_q_stat   i_q_stat,
    output logic               o_push,
    output csl_pkg::t_entry    o_entry
);

    csl_pkg::t_mode r_mode;
    csl_pkg::t_mode n_mode;
    logic           accept;
    logic [7:0]     c;

    function automatic logic is_space(input logic [7:0] v);
        return (v == 8'd32) || ((v >= 8'd9) && (v <= 8'd13));
    endfunction

    function automatic logic is_digit(input logic [7:0] v);
        return (v >= 8'd48) && (v <= 8'd57);
    endfunction

    function automatic logic is_alpha(input logic [7:0] v);
        return ((v >= 8'd65) && (v <= 8'd90)) || ((v >= 8'd97) && (v <= 8'd122));
    endfunction

    function automatic csl_pkg::t_result mk(input csl_pkg::t_kind k, input logic [7:0] v,
                                             input logic p, input logic l);
        csl_pkg::t_result r;
        r.kind    = k;
        r.ch      = v;
        r.present = p;
        r.last    = l;
        return r;
    endfunction

    // Result of a character met with no token open
    function automatic csl_pkg::t_result idle_result(input logic [7:0] v);
        csl_pkg::t_result r;
        if (is_digit(v)) begin
            r = mk(csl_pkg::KIND_NUMBER, v, 1'b1, 1'b0);
        end else if (is_alpha(v)) begin
            r = mk(csl_pkg::KIND_SYMBOL, v, 1'b1, 1'b0);
        end else if (v == csl_pkg::CHAR_SEMI) begin
            r = mk(csl_pkg::KIND_SEMI, v, 1'b1, 1'b1);
        end else if (v == csl_pkg::CHAR_COLON) begin
            r = mk(csl_pkg::KIND_COLON, v, 1'b1, 1'b1);
        end else if (v == csl_pkg::CHAR_LPAR) begin
            r = mk(csl_pkg::KIND_LPAR, v, 1'b1, 1'b1);
        end else if (v == csl_pkg::CHAR_RPAR) begin
            r = mk(csl_pkg::KIND_RPAR, v, 1'b1, 1'b1);
        end else begin
            r = mk(csl_pkg::KIND_ERROR, v, 1'b1, 1'b1);
        end
        return r;
    endfunction

    // Whitespace and a held equals sign give nothing at once
    function automatic logic idle_emits(input logic [7:0] v);
        return !is_space(v) && (v != csl_pkg::CHAR_EQ);
    endfunction

    function automatic csl_pkg::t_mode idle_mode(input logic [7:0] v);
        csl_pkg::t_mode m;
        if (is_digit(v)) begin
            m = csl_pkg::MODE_INT;
        end else if (is_alpha(v)) begin
            m = csl_pkg::MODE_SYM;
        end else if (v == csl_pkg::CHAR_EQ) begin
            m = csl_pkg::MODE_EQ;
        end else begin
            m = csl_pkg::MODE_IDLE;
        end
        return m;
    endfunction

    assign c          = i_in.char_code;
    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;

    // Next mode
    always_comb begin
        n_mode = r_mode;
        if (accept) begin
            if (i_in.end_of_stream) begin
                n_mode = csl_pkg::MODE_IDLE;
            end else begin
                case (r_mode)
                    csl_pkg::MODE_INT: begin
                        if (is_digit(c)) n_mode = csl_pkg::MODE_INT;
                        else if (c == csl_pkg::CHAR_DOT) n_mode = csl_pkg::MODE_FRAC;
                        else n_mode = idle_mode(c);
                    end
                    csl_pkg::MODE_FRAC: begin
                        if (is_digit(c)) n_mode = csl_pkg::MODE_FRAC;
                        else n_mode = idle_mode(c);
                    end
                    csl_pkg::MODE_SYM: begin
                        if (is_alpha(c) || is_digit(c)) n_mode = csl_pkg::MODE_SYM;
                        else n_mode = idle_mode(c);
                    end
                    csl_pkg::MODE_EQ: begin
                        if (c == csl_pkg::CHAR_GT) n_mode = csl_pkg::MODE_IDLE;
                        else n_mode = idle_mode(c);
                    end
                    default: n_mode = idle_mode(c);
                endcase
            end
        end
    end

    // Results of the current item
    always_comb begin
        logic emit;
        logic close;
        emit          = 1'b0;
        close         = 1'b0;
        o_entry.res0  = mk(csl_pkg::KIND_EOF, 8'd0, 1'b0, 1'b1);
        o_entry.res1  = mk(csl_pkg::KIND_EOF, 8'd0, 1'b0, 1'b1);
        o_entry.two   = 1'b0;
        if (i_in.end_of_stream) begin
            emit = 1'b1;
            case (r_mode)
                csl_pkg::MODE_INT, csl_pkg::MODE_FRAC: begin
                    o_entry.res0 = mk(csl_pkg::KIND_NUMBER, 8'd0, 1'b0, 1'b1);
                    o_entry.two  = 1'b1;
                end
                csl_pkg::MODE_SYM: begin
                    o_entry.res0 = mk(csl_pkg::KIND_SYMBOL, 8'd0, 1'b0, 1'b1);
                    o_entry.two  = 1'b1;
                end
                csl_pkg::MODE_EQ: begin
                    o_entry.res0 = mk(csl_pkg::KIND_EQUAL, csl_pkg::CHAR_EQ, 1'b1, 1'b1);
                    o_entry.two  = 1'b1;
                end
                default: o_entry.two = 1'b0;
            endcase
        end else begin
            case (r_mode)
                csl_pkg::MODE_INT: begin
                    if (is_digit(c) || (c == csl_pkg::CHAR_DOT)) begin
                        emit         = 1'b1;
                        o_entry.res0 = mk(csl_pkg::KIND_NUMBER, c, 1'b1, 1'b0);
                    end else begin
                        close        = 1'b1;
                        o_entry.res0 = mk(csl_pkg::KIND_NUMBER, 8'd0, 1'b0, 1'b1);
                    end
                end
                csl_pkg::MODE_FRAC: begin
                    if (is_digit(c)) begin
                        emit         = 1'b1;
                        o_entry.res0 = mk(csl_pkg::KIND_NUMBER, c, 1'b1, 1'b0);
                    end else begin
                        close        = 1'b1;
                        o_entry.res0 = mk(csl_pkg::KIND_NUMBER, 8'd0, 1'b0, 1'b1);
                    end
                end
                csl_pkg::MODE_SYM: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        emit         = 1'b1;
                        o_entry.res0 = mk(csl_pkg::KIND_SYMBOL, c, 1'b1, 1'b0);
                    end else begin
                        close        = 1'b1;
                        o_entry.res0 = mk(csl_pkg::KIND_SYMBOL, 8'd0, 1'b0, 1'b1);
                    end
                end
                csl_pkg::MODE_EQ: begin
                    if (c == csl_pkg::CHAR_GT) begin
                        emit         = 1'b1;
                        o_entry.res0 = mk(csl_pkg::KIND_ARROW, csl_pkg::CHAR_EQ, 1'b1, 1'b0);
                        o_entry.res1 = mk(csl_pkg::KIND_ARROW, c, 1'b1, 1'b1);
                        o_entry.two  = 1'b1;
                    end else begin
                        close        = 1'b1;
                        o_entry.res0 = mk(csl_pkg::KIND_EQUAL, csl_pkg::CHAR_EQ, 1'b1, 1'b1);
                    end
                end
                default: begin
                    emit         = idle_emits(c);
                    o_entry.res0 = idle_result(c);
                end
            endcase
            // A closing result may be followed by the character's own token
            if (close) begin
                emit         = 1'b1;
                o_entry.res1 = idle_result(c);
                o_entry.two  = idle_emits(c);
            end
        end
        o_push = accept && emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= csl_pkg::MODE_IDLE;
        end else begin
            r_mode <= n_mode;
        end
    end

endmodule

// ===== hw/rtl/csl_queue.sv =====
// Short register queue of result entries between lexer front and back end.
`timescale 1ns / 1ps

module csl_queue #(
    parameter int DEPTH = csl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  csl_pkg::t_entry   i_entry,
    input  logic              i_pop,
    output csl_pkg::t_entry   o_head,
    output csl_pkg::t_q_stat  o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    csl_pkg::t_entry  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/csl_back.sv =====
// Lexer back end: unpacks queue entries into single result transfers.
`timescale 1ns / 1ps

module csl_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  csl_pkg::t_entry   i_head,
    input  csl_pkg::t_q_stat  i_q_stat,
    output logic              o_pop,
    csl_out_if.source         o_out
);

    logic             r_valid;
    logic             r_second;
    csl_pkg::t_entry  r_entry;
    csl_pkg::t_result cur;
    logic             take;
    logic             finish;
    logic             load;

    assign cur    = r_second ? r_entry.res1 : r_entry.res0;
    assign take   = o_out.valid && o_out.ready;
    assign finish = take && (r_second || !r_entry.two);
    assign load   = !r_valid || finish;
    assign o_pop  = load && !i_q_stat.empty;

    assign o_out.valid        = r_valid;
    assign o_out.token_kind   = cur.kind;
    assign o_out.token_char   = cur.ch;
    assign o_out.char_present = cur.present;
    assign o_out.token_last   = cur.last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid  <= !i_q_stat.empty;
            r_second <= 1'b0;
        end else if (take) begin
            r_second <= 1'b1;
        end
    end

endmodule

// ===== hw/rtl/char_stream_lexer.sv =====
// Top level of the character stream lexer: front end, entry queue and back end.
`timescale 1ns / 1ps

// The lexer takes one ASCII byte, or an end-of-stream mark, per input
// transfer and emits every character that belongs to a token as one result
// transfer tagged with the token type; whitespace between tokens is dropped.
// Numbers (digits, optionally a dot and more digits) and symbols (a letter
// then letters or digits) are closed by an end-only result when a character
// outside them arrives, and that character is then handled in its own
// right. An equals sign is held back one character so that "=>" gives two
// arrow results. End of stream closes any open token and emits an EOF
// result. Input is taken at one item per cycle; an item that causes two
// results occupies the single-result output for both transfers, and the
// entry queue (QUEUE_DEPTH entries, default four) absorbs that so input
// keeps flowing until the queue fills. An accepted item is written into
// the queue and then loaded into the output register before its first
// result appears.

module char_stream_lexer #(
    parameter int QUEUE_DEPTH = csl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csl_in_if.sink     i_in,
    csl_out_if.source  o_out
);

    logic              push;
    logic              pop;
    csl_pkg::t_entry   push_entry;
    csl_pkg::t_entry   head_entry;
    csl_pkg::t_q_stat  q_stat;

    // Classify each transfer; the front stalls only when the queue is full
    csl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    // Hold up to QUEUE_DEPTH pending entries of one or two results each
    csl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_stat  (q_stat)
    );

    // Serialise entries onto the result channel, one result per transfer
    csl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_entry),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

// ===== verif/csl_lexer_checker.sv =====
// Checker of the character stream lexer: predicts every token result and compares it.
`timescale 1ns / 1ps

module csl_lexer_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    csl_in_if    i_in_mon,
    csl_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);

    csl_pkg::t_mode   scan_mode;
    csl_pkg::t_result token_q[$];
    int               mismatches = 0;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic void add_token(input csl_pkg::t_kind k, input logic [7:0] c,
                                      input logic present, input logic last);
        csl_pkg::t_result r;
        r.kind    = k;
        r.ch      = c;
        r.present = present;
        r.last    = last;
        token_q   = {token_q, r};
    endfunction

    // Handle a character as if no token were open
    function automatic void open_token(input logic [7:0] c);
        scan_mode = csl_pkg::MODE_IDLE;
        if (is_blank(c)) begin
            scan_mode = csl_pkg::MODE_IDLE;
        end else if (is_digit(c)) begin
            scan_mode = csl_pkg::MODE_INT;
            add_token(csl_pkg::KIND_NUMBER, c, 1'b1, 1'b0);
        end else if (is_letter(c)) begin
            scan_mode = csl_pkg::MODE_SYM;
            add_token(csl_pkg::KIND_SYMBOL, c, 1'b1, 1'b0);
        end else begin
            case (c)
                csl_pkg::CHAR_SEMI:  add_token(csl_pkg::KIND_SEMI, c, 1'b1, 1'b1);
                csl_pkg::CHAR_COLON: add_token(csl_pkg::KIND_COLON, c, 1'b1, 1'b1);
                csl_pkg::CHAR_LPAR:  add_token(csl_pkg::KIND_LPAR, c, 1'b1, 1'b1);
                csl_pkg::CHAR_RPAR:  add_token(csl_pkg::KIND_RPAR, c, 1'b1, 1'b1);
                csl_pkg::CHAR_EQ:    scan_mode = csl_pkg::MODE_EQ;
                default:             add_token(csl_pkg::KIND_ERROR, c, 1'b1, 1'b1);
            endcase
        end
    endfunction

    // Close the open number or symbol, then take the character afresh
    function automatic void close_then_open(input csl_pkg::t_kind k, input logic [7:0] c);
        add_token(k, 8'h00, 1'b0, 1'b1);
        open_token(c);
    endfunction

    function automatic void scan_item(input logic [7:0] c, input logic eos);
        if (eos) begin
            case (scan_mode)
                csl_pkg::MODE_INT, csl_pkg::MODE_FRAC:
                    add_token(csl_pkg::KIND_NUMBER, 8'h00, 1'b0, 1'b1);
                csl_pkg::MODE_SYM:
                    add_token(csl_pkg::KIND_SYMBOL, 8'h00, 1'b0, 1'b1);
                csl_pkg::MODE_EQ:
                    add_token(csl_pkg::KIND_EQUAL, csl_pkg::CHAR_EQ, 1'b1, 1'b1);
                default: ;
            endcase
            add_token(csl_pkg::KIND_EOF, 8'h00, 1'b0, 1'b1);
            scan_mode = csl_pkg::MODE_IDLE;
        end else begin
            case (scan_mode)
                csl_pkg::MODE_INT: begin
                    if (is_digit(c)) begin
                        add_token(csl_pkg::KIND_NUMBER, c, 1'b1, 1'b0);
                    end else if (c == csl_pkg::CHAR_DOT) begin
                        scan_mode = csl_pkg::MODE_FRAC;
                        add_token(csl_pkg::KIND_NUMBER, c, 1'b1, 1'b0);
                    end else begin
                        close_then_open(csl_pkg::KIND_NUMBER, c);
                    end
                end
                csl_pkg::MODE_FRAC: begin
                    if (is_digit(c)) add_token(csl_pkg::KIND_NUMBER, c, 1'b1, 1'b0);
                    else close_then_open(csl_pkg::KIND_NUMBER, c);
                end
                csl_pkg::MODE_SYM: begin
                    if (is_letter(c) || is_digit(c))
                        add_token(csl_pkg::KIND_SYMBOL, c, 1'b1, 1'b0);
                    else close_then_open(csl_pkg::KIND_SYMBOL, c);
                end
                csl_pkg::MODE_EQ: begin
                    if (c == csl_pkg::CHAR_GT) begin
                        scan_mode = csl_pkg::MODE_IDLE;
                        add_token(csl_pkg::KIND_ARROW, csl_pkg::CHAR_EQ, 1'b1, 1'b0);
                        add_token(csl_pkg::KIND_ARROW, c, 1'b1, 1'b1);
                    end else begin
                        add_token(csl_pkg::KIND_EQUAL, csl_pkg::CHAR_EQ, 1'b1, 1'b1);
                        open_token(c);
                    end
                end
                default: open_token(c);
            endcase
        end
    endfunction

    always @(posedge i_clk) begin : watch
        csl_pkg::t_result want;
        if (!i_rst_n) begin
            scan_mode = csl_pkg::MODE_IDLE;
            token_q.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready)
                scan_item(i_in_mon.char_code, i_in_mon.end_of_stream);
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (token_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: kind %0d char %02h present %0b last %0b",
                             $time, i_out_mon.token_kind, i_out_mon.token_char,
                             i_out_mon.char_present, i_out_mon.token_last);
                end else begin
                    want = token_q.pop_front();
                    if (want.kind !== i_out_mon.token_kind || want.ch !== i_out_mon.token_char
                        || want.present !== i_out_mon.char_present
                        || want.last !== i_out_mon.token_last) begin
                        mismatches++;
                        $display("%0t: mismatch: expected kind %0d char %02h present %0b last %0b",
                                 $time, want.kind, want.ch, want.present, want.last);
                        $display("%0t:           actual kind %0d char %02h present %0b last %0b",
                                 $time, i_out_mon.token_kind, i_out_mon.token_char,
                                 i_out_mon.char_present, i_out_mon.token_last);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= token_q.size();
    end

endmodule

// ===== verif/tb_char_stream_lexer.sv =====
// Testbench top of the character stream lexer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_char_stream_lexer;

    // Input items per random phase
    localparam int PHASE_ITEMS = 460;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    localparam logic [7:0] PUNCT [4] = '{csl_pkg::CHAR_SEMI, csl_pkg::CHAR_COLON,
                                         csl_pkg::CHAR_LPAR, csl_pkg::CHAR_RPAR};

    // Directed opening: {end_of_stream, char_code}. It runs a symbol closed by a
    // blank, a number with fraction closed by a second dot (an error), the single
    // punctuation, an arrow, a held equals closed by a colon and by another equals,
    // end of stream with an equals, a symbol and a number still open, the byte
    // extremes as errors, and end of stream with nothing open.
    localparam logic [8:0] DIRECTED [27] = '{
        {1'b0, "a"},               {1'b0, "Z"},
        {1'b0, "9"},               {1'b0, CH_SPACE},
        {1'b0, "0"},               {1'b0, "7"},
        {1'b0, csl_pkg::CHAR_DOT}, {1'b0, "5"},
        {1'b0, csl_pkg::CHAR_DOT}, {1'b0, csl_pkg::CHAR_LPAR},
        {1'b0, csl_pkg::CHAR_SEMI}, {1'b0, csl_pkg::CHAR_RPAR},
        {1'b0, csl_pkg::CHAR_EQ},  {1'b0, csl_pkg::CHAR_GT},
        {1'b0, csl_pkg::CHAR_EQ},  {1'b0, csl_pkg::CHAR_COLON},
        {1'b0, csl_pkg::CHAR_EQ},  {1'b0, csl_pkg::CHAR_EQ},
        {1'b1, 8'h00},             {1'b0, "z"},
        {1'b1, 8'hFF},             {1'b0, 8'h00},
        {1'b0, 8'hFF},             {1'b0, CH_TAB},
        {1'b0, "5"},               {1'b1, 8'h7F},
        {1'b1, 8'h80}
    };

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   items_sent = 0;

    csl_in_if  lex_in ();
    csl_out_if tok_out ();

    char_stream_lexer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (lex_in),
        .o_out   (tok_out)
    );

    csl_lexer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (lex_in),
        .i_out_mon    (tok_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Stall the result channel at the rate the current phase asks
    always @(posedge i_clk) begin
        tok_out.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Hard stop, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("** char_stream_lexer: FAILED **");
        $finish;
    end

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(1) == 0) return 8'(CH_UPPER_A + $urandom_range(25));
        return 8'(CH_LOWER_A + $urandom_range(25));
    endfunction

    // Space, or one of tab through carriage return
    function automatic logic [7:0] rand_blank();
        if ($urandom_range(6) == 6) return CH_SPACE;
        return 8'(CH_TAB + $urandom_range(4));
    endfunction

    // Offer one item and hold it until the transfer; idle first at the
    // phase's rate. Valid is raised only once per edge, so a back-to-back
    // stream keeps it high without a glitch.
    task automatic send_byte(input logic [7:0] c, input logic eos);
        while ($urandom_range(99) < tx_idle_pct) begin
            lex_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        lex_in.valid         <= 1'b1;
        lex_in.char_code     <= c;
        lex_in.end_of_stream <= eos;
        @(posedge i_clk);
        while (!lex_in.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic hold_until_drained();
        lex_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // One well-formed token with random content, now and then noise or an
    // end of stream. Tokens often abut, so a number or symbol gets closed by
    // whatever comes next.
    task automatic send_token();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            repeat ($urandom_range(4, 1)) send_byte(rand_digit(), 1'b0);
            if ($urandom_range(99) < 40) begin
                send_byte(csl_pkg::CHAR_DOT, 1'b0);
                repeat ($urandom_range(3)) send_byte(rand_digit(), 1'b0);
            end
        end else if (pick < 55) begin
            send_byte(rand_letter(), 1'b0);
            repeat ($urandom_range(5))
                send_byte(($urandom_range(2) == 0) ? rand_digit() : rand_letter(), 1'b0);
        end else if (pick < 70) begin
            send_byte(PUNCT[2'($urandom_range(3))], 1'b0);
        end else if (pick < 78) begin
            send_byte(csl_pkg::CHAR_EQ, 1'b0);
            send_byte(csl_pkg::CHAR_GT, 1'b0);
        end else if (pick < 84) begin
            send_byte(csl_pkg::CHAR_EQ, 1'b0);
        end else if (pick < 91) begin
            repeat ($urandom_range(3, 1)) send_byte(rand_blank(), 1'b0);
        end else if (pick < 97) begin
            send_byte(8'($urandom_range(255)), 1'b0);
        end else begin
            send_byte(8'($urandom_range(255)), 1'b1);
        end
    endtask

    initial begin
        int phase_goal;
        // Known values on every input before the first edge
        lex_in.valid         = 1'b0;
        lex_in.char_code     = 8'h00;
        lex_in.end_of_stream = 1'b0;
        tok_out.ready        = 1'b0;
        i_rst_n              = 1'b0;
        tx_idle_pct          = 32;
        rx_idle_pct          = 88;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k]) send_byte(DIRECTED[k][7:0], DIRECTED[k][8]);
        hold_until_drained();

        // Sender idles lightly against a slow receiver, then the other way
        // round, then both run flat out
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 88 : 0;
            rx_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 32 : 0;
            phase_goal  = items_sent + PHASE_ITEMS;
            while (items_sent < phase_goal) begin
                send_token();
                if ($urandom_range(1) == 0) send_byte(rand_blank(), 1'b0);
                if ($urandom_range(199) == 0) hold_until_drained();
            end
            hold_until_drained();
        end

        // Allow for the pipeline after the last result, and for items that
        // cause no result but may still be in flight
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** char_stream_lexer: PASSED **");
        end else begin
            $display("** char_stream_lexer: FAILED **");
        end
        $finish;
    end

endmodule
